>>> src/ycf_pkg.sv
// Shared types, codes and constants of the Yee cell correction factor unit.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package ycf_pkg;

    // Default grid bounds.
    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;

    // Field and register widths.
    localparam int SIZE_W     = 7;
    localparam int GAIN_W     = 31;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 31;
    localparam int DATA_W     = 32;
    localparam int COORD_W    = 6;

    // Reset value of both grid size registers.
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    // One quotient bit per step of the divider.
    localparam int DIV_ITER = 48;
    localparam int ITER_W   = $clog2(DIV_ITER);

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ETA_GAIN    = 2'd2;

    typedef enum logic [1:0] {
        KIND_CELL,
        KIND_LOWER,
        KIND_UPPER,
        KIND_QUERY
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WR_CELL,
        ST_WR_LAYER,
        ST_RD,
        ST_ACC,
        ST_MUL,
        ST_MACC,
        ST_DIV_INIT,
        ST_DIV_RUN,
        ST_DIV_END
    } state_t;

    // Operations of the shared multiplier, in issue order.
    typedef enum logic [2:0] {
        OP_E,
        OP_PAPB,
        OP_PBSF,
        OP_SFPA,
        OP_T,
        OP_ETA
    } mul_op_t;

    // Neighbour offset along one axis.
    typedef enum logic [1:0] {
        NB_SAME,
        NB_PLUS,
        NB_MINUS
    } nbr_t;

    // Where one neighbour value of a query comes from.
    typedef struct packed {
        logic       layer;
        logic [1:0] comp;
        logic       hf;
        nbr_t       dx;
        nbr_t       dy;
    } slot_src_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_item;
        logic       wr_cell;
        logic       wr_layer;
        logic       rd;
        logic       acc;
        logic       mul;
        logic       macc;
        logic       div_init;
        logic       div_step;
        logic       div_end;
        logic       emit;
        logic [1:0] comp;
        logic [2:0] slot;
        mul_op_t    op;
    } ycf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic  in_range;
        kind_t kind;
        logic  half;
    } ycf_status_t;

    // Neighbour table: component pattern j (3*half + component) and slot k.
    // Slots 0 and 1 form the first factor pair, slots 2 and 3 the second.
    function automatic slot_src_t slot_src(input logic [2:0] j, input logic [1:0] k);
        slot_src_t s;
        begin
            unique case ({j, k})
                5'b000_00: s = '{1'b0, 2'd0, 1'b1, NB_SAME,  NB_SAME};
                5'b000_01: s = '{1'b1, 2'd0, 1'b0, NB_SAME,  NB_SAME};
                5'b000_10: s = '{1'b0, 2'd2, 1'b0, NB_SAME,  NB_SAME};
                5'b000_11: s = '{1'b0, 2'd2, 1'b0, NB_SAME,  NB_MINUS};
                5'b001_00: s = '{1'b0, 2'd1, 1'b1, NB_SAME,  NB_SAME};
                5'b001_01: s = '{1'b1, 2'd0, 1'b0, NB_SAME,  NB_SAME};
                5'b001_10: s = '{1'b0, 2'd2, 1'b0, NB_SAME,  NB_SAME};
                5'b001_11: s = '{1'b0, 2'd2, 1'b0, NB_MINUS, NB_SAME};
                5'b010_00: s = '{1'b0, 2'd0, 1'b0, NB_SAME,  NB_SAME};
                5'b010_01: s = '{1'b0, 2'd0, 1'b0, NB_SAME,  NB_PLUS};
                5'b010_10: s = '{1'b0, 2'd1, 1'b0, NB_SAME,  NB_SAME};
                5'b010_11: s = '{1'b0, 2'd1, 1'b0, NB_PLUS,  NB_SAME};
                5'b011_00: s = '{1'b0, 2'd0, 1'b0, NB_SAME,  NB_SAME};
                5'b011_01: s = '{1'b1, 2'd0, 1'b0, NB_SAME,  NB_SAME};
                5'b011_10: s = '{1'b0, 2'd2, 1'b1, NB_SAME,  NB_SAME};
                5'b011_11: s = '{1'b0, 2'd2, 1'b1, NB_PLUS,  NB_SAME};
                5'b100_00: s = '{1'b0, 2'd1, 1'b0, NB_SAME,  NB_SAME};
                5'b100_01: s = '{1'b1, 2'd0, 1'b0, NB_SAME,  NB_SAME};
                5'b100_10: s = '{1'b0, 2'd2, 1'b1, NB_SAME,  NB_SAME};
                5'b100_11: s = '{1'b0, 2'd2, 1'b1, NB_SAME,  NB_PLUS};
                5'b101_00: s = '{1'b0, 2'd0, 1'b1, NB_SAME,  NB_SAME};
                5'b101_01: s = '{1'b0, 2'd0, 1'b1, NB_MINUS, NB_SAME};
                5'b101_10: s = '{1'b0, 2'd1, 1'b1, NB_SAME,  NB_SAME};
                5'b101_11: s = '{1'b0, 2'd1, 1'b1, NB_SAME,  NB_MINUS};
                default:   s = '{1'b0, 2'd0, 1'b0, NB_SAME,  NB_SAME};
            endcase
            return s;
        end
    endfunction

endpackage

>>> src/yee_cell_correction_factor_unit.sv
// Top level of the Yee cell correction factor unit.
// Instantiates ycf_ctrl and ycf_datapath; types and constants from ycf_pkg.
`timescale 1ns / 1ps

// Channel   | Handshake                 | Payload
// ----------+---------------------------+-------------------------------------------
// input     | start, busy               | kind, cell_x, cell_y, half, med_*, fac_*
// result    | done (one-cycle strobe)   | out_x, out_y, out_half, corrected_*, saturated
// config    | cfg_we                    | cfg_addr, cfg_wdata
//
// An item is taken when start is high and busy is low. A cell or layer record
// load goes through one store write port per cycle. A query works through each
// component in turn: neighbour reads, the shared multiplier and the bit-serial
// divider. An item out of the grid or a layer record for the wrong half is
// dropped after decode. Reset clears the control state, the configuration, the
// saturation flag and done; the stores hold no reset value.
// The receiver cannot stall. The result is valid only in the cycle in which
// done is high; the position and flag outputs change once the next item is taken.

module yee_cell_correction_factor_unit #(
    parameter int MAX_WIDTH  = ycf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ycf_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              cfg_we,
    input  logic [ycf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [ycf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [1:0]                        kind,
    input  logic [ycf_pkg::COORD_W-1:0]       cell_x,
    input  logic [ycf_pkg::COORD_W-1:0]       cell_y,
    input  logic                              half,
    input  logic signed [ycf_pkg::DATA_W-1:0] med_a,
    input  logic signed [ycf_pkg::DATA_W-1:0] med_b,
    input  logic signed [ycf_pkg::DATA_W-1:0] med_c,
    input  logic signed [ycf_pkg::DATA_W-1:0] fac_a,
    input  logic signed [ycf_pkg::DATA_W-1:0] fac_b,
    input  logic signed [ycf_pkg::DATA_W-1:0] fac_c,
    output logic                              done,
    output logic [ycf_pkg::COORD_W-1:0]       out_x,
    output logic [ycf_pkg::COORD_W-1:0]       out_y,
    output logic                              out_half,
    output logic signed [ycf_pkg::DATA_W-1:0] corrected_a,
    output logic signed [ycf_pkg::DATA_W-1:0] corrected_b,
    output logic signed [ycf_pkg::DATA_W-1:0] corrected_c,
    output logic                              saturated
);
    import ycf_pkg::*;

    ycf_cmd_t    cmd;
    ycf_status_t status;

    // Sequencer.
    ycf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    // Stores and arithmetic.
    ycf_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .kind        (kind),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .half        (half),
        .med_a       (med_a),
        .med_b       (med_b),
        .med_c       (med_c),
        .fac_a       (fac_a),
        .fac_b       (fac_b),
        .fac_c       (fac_c),
        .done        (done),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_half    (out_half),
        .corrected_a (corrected_a),
        .corrected_b (corrected_b),
        .corrected_c (corrected_c),
        .saturated   (saturated)
    );

endmodule

>>> src/ycf_ctrl.sv
// Controller of the correction factor unit: sequences loads and queries.
// Depends on ycf_pkg for the state, command and status types.
`timescale 1ns / 1ps

module ycf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ycf_pkg::ycf_status_t status,
    output ycf_pkg::ycf_cmd_t   cmd
);
    import ycf_pkg::*;

    state_t            state_reg, state_next;
    logic [1:0]        comp_reg, comp_next;
    logic [2:0]        slot_reg, slot_next;
    mul_op_t           op_reg, op_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              layer_ok;

    // A layer record is kept only for its own half.
    assign layer_ok = ((status.kind == KIND_LOWER) && status.half) ||
                      ((status.kind == KIND_UPPER) && !status.half);

    // State and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            comp_reg  <= '0;
            slot_reg  <= '0;
            op_reg    <= OP_E;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            comp_reg  <= comp_next;
            slot_reg  <= slot_next;
            op_reg    <= op_next;
            iter_reg  <= iter_next;
        end
    end

    // Next state and counter values.
    always_comb
    begin
        state_next = state_reg;
        comp_next  = comp_reg;
        slot_next  = slot_reg;
        op_next    = op_reg;
        iter_next  = iter_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                comp_next = '0;
                slot_next = '0;
                if (!status.in_range)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    unique case (status.kind)
                        KIND_CELL:  state_next = ST_WR_CELL;
                        KIND_LOWER,
                        KIND_UPPER: state_next = layer_ok ? ST_WR_LAYER : ST_IDLE;
                        KIND_QUERY: state_next = ST_RD;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WR_CELL:
            begin
                if (comp_reg == 2'd2)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    comp_next = comp_reg + 2'd1;
                end
            end
            ST_WR_LAYER:
            begin
                if (comp_reg == 2'd1)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    comp_next = comp_reg + 2'd1;
                end
            end
            ST_RD:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (slot_reg == 3'd4)
                begin
                    state_next = ST_MUL;
                    op_next    = OP_E;
                end
                else
                begin
                    state_next = ST_RD;
                    slot_next  = slot_reg + 3'd1;
                end
            end
            ST_MUL:
            begin
                state_next = ST_MACC;
            end
            ST_MACC:
            begin
                if (op_reg == OP_ETA)
                begin
                    state_next = ST_DIV_INIT;
                end
                else
                begin
                    state_next = ST_MUL;
                    op_next    = mul_op_t'(op_reg + 3'd1);
                end
            end
            ST_DIV_INIT:
            begin
                state_next = ST_DIV_RUN;
                iter_next  = '0;
            end
            ST_DIV_RUN:
            begin
                if (iter_reg == ITER_W'(DIV_ITER - 1))
                begin
                    state_next = ST_DIV_END;
                end
                else
                begin
                    iter_next = iter_reg + ITER_W'(1);
                end
            end
            ST_DIV_END:
            begin
                if (comp_reg == 2'd2)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_RD;
                    comp_next  = comp_reg + 2'd1;
                    slot_next  = '0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd           = '0;
        cmd.comp      = comp_reg;
        cmd.slot      = slot_reg;
        cmd.op        = op_reg;
        cmd.load_item = start && (state_reg == ST_IDLE);
        cmd.wr_cell   = (state_reg == ST_WR_CELL);
        cmd.wr_layer  = (state_reg == ST_WR_LAYER);
        cmd.rd        = (state_reg == ST_RD);
        cmd.acc       = (state_reg == ST_ACC);
        cmd.mul       = (state_reg == ST_MUL);
        cmd.macc      = (state_reg == ST_MACC);
        cmd.div_init  = (state_reg == ST_DIV_INIT);
        cmd.div_step  = (state_reg == ST_DIV_RUN);
        cmd.div_end   = (state_reg == ST_DIV_END);
        cmd.emit      = (state_reg == ST_DIV_END) && (comp_reg == 2'd2);
        busy          = (state_reg != ST_IDLE);
    end

    // An accepted item is always decoded in the following cycle.
    a_load_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_item |=> state_reg == ST_DECODE)
        else $error("accepted item not decoded");

    // The divider never runs past its number of steps.
    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV_RUN |-> iter_reg <= ITER_W'(DIV_ITER - 1))
        else $error("divider step count overrun");

    // A result is emitted only for the last component.
    a_emit_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> state_reg == ST_IDLE)
        else $error("result emitted before the last component");

endmodule

>>> src/ycf_datapath.sv
// Datapath of the correction factor unit: stores, neighbour reads, shared
// multiplier and a bit-serial divider. Depends on ycf_pkg.
`timescale 1ns / 1ps

module ycf_datapath #(
    parameter int MAX_WIDTH  = ycf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ycf_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ycf_pkg::ycf_cmd_t                    cmd,
    output ycf_pkg::ycf_status_t                 status,
    input  logic                                 cfg_we,
    input  logic [ycf_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [ycf_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic [1:0]                           kind,
    input  logic [ycf_pkg::COORD_W-1:0]          cell_x,
    input  logic [ycf_pkg::COORD_W-1:0]          cell_y,
    input  logic                                 half,
    input  logic signed [ycf_pkg::DATA_W-1:0]    med_a,
    input  logic signed [ycf_pkg::DATA_W-1:0]    med_b,
    input  logic signed [ycf_pkg::DATA_W-1:0]    med_c,
    input  logic signed [ycf_pkg::DATA_W-1:0]    fac_a,
    input  logic signed [ycf_pkg::DATA_W-1:0]    fac_b,
    input  logic signed [ycf_pkg::DATA_W-1:0]    fac_c,
    output logic                                 done,
    output logic [ycf_pkg::COORD_W-1:0]          out_x,
    output logic [ycf_pkg::COORD_W-1:0]          out_y,
    output logic                                 out_half,
    output logic signed [ycf_pkg::DATA_W-1:0]    corrected_a,
    output logic signed [ycf_pkg::DATA_W-1:0]    corrected_b,
    output logic signed [ycf_pkg::DATA_W-1:0]    corrected_c,
    output logic                                 saturated
);
    import ycf_pkg::*;

    localparam int CELLS     = MAX_WIDTH * MAX_HEIGHT;
    localparam int MED_DEPTH = 6 * CELLS;
    localparam int LAY_DEPTH = 2 * CELLS;
    localparam int MAW       = $clog2(MED_DEPTH);
    localparam int LAW       = $clog2(LAY_DEPTH);
    localparam int CW        = SIZE_W;

    // Address of a cell store entry.
    function automatic logic [MAW-1:0] med_addr(input logic [1:0] c, input logic hf,
                                                 input logic [CW-1:0] cx,
                                                 input logic [CW-1:0] cy);
        begin
            return MAW'(c) + MAW'(3) * MAW'(hf)
                 + MAW'(6) * (MAW'(cx) + MAW'(MAX_WIDTH) * MAW'(cy));
        end
    endfunction

    // Address of a layer store entry.
    function automatic logic [LAW-1:0] lay_addr(input logic c, input logic [CW-1:0] cx,
                                                input logic [CW-1:0] cy);
        begin
            return LAW'(2) * (LAW'(cx) + LAW'(MAX_WIDTH) * LAW'(cy)) + LAW'(c);
        end
    endfunction

    // Saturation to 32 bits; the top bit of the result is the flag.
    function automatic logic [DATA_W:0] sat32(input logic signed [51:0] v);
        begin
            if (v > 52'sd2147483647)
            begin
                return {1'b1, 32'h7FFF_FFFF};
            end
            else if (v < -52'sd2147483648)
            begin
                return {1'b1, 32'h8000_0000};
            end
            else
            begin
                return {1'b0, v[DATA_W-1:0]};
            end
        end
    endfunction

    // Configuration registers.
    logic [SIZE_W-1:0] grid_w_reg, grid_h_reg;
    logic [GAIN_W-1:0] gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_w_reg <= SIZE_RESET;
            grid_h_reg <= SIZE_RESET;
            gain_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_GRID_WIDTH:  grid_w_reg <= cfg_wdata[SIZE_W-1:0];
                REG_GRID_HEIGHT: grid_h_reg <= cfg_wdata[SIZE_W-1:0];
                REG_ETA_GAIN:    gain_reg   <= cfg_wdata[GAIN_W-1:0];
                default:         ;
            endcase
        end
    end

    // Latched item.
    kind_t                    kind_reg;
    logic [COORD_W-1:0]       x_reg, y_reg;
    logic                     h_reg;
    logic signed [DATA_W-1:0] ma_reg, mb_reg, mc_reg, fa_reg, fb_reg, fc_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg <= kind_t'(kind);
            x_reg    <= cell_x;
            y_reg    <= cell_y;
            h_reg    <= half;
            ma_reg   <= med_a;
            mb_reg   <= med_b;
            mc_reg   <= med_c;
            fa_reg   <= fac_a;
            fb_reg   <= fac_b;
            fc_reg   <= fac_c;
        end
    end

    // Effective grid size and wrapped neighbour coordinates.
    logic [CW-1:0] w_eff, h_eff, xx, yy, xp, xm, yp, ym;

    always_comb
    begin
        if (grid_w_reg == '0)
        begin
            w_eff = CW'(1);
        end
        else if (int'(grid_w_reg) > MAX_WIDTH)
        begin
            w_eff = CW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = grid_w_reg;
        end
        if (grid_h_reg == '0)
        begin
            h_eff = CW'(1);
        end
        else if (int'(grid_h_reg) > MAX_HEIGHT)
        begin
            h_eff = CW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = grid_h_reg;
        end
        xx = CW'(x_reg);
        yy = CW'(y_reg);
        xp = (xx + CW'(1) == w_eff) ? '0 : xx + CW'(1);
        xm = (xx == '0) ? w_eff - CW'(1) : xx - CW'(1);
        yp = (yy + CW'(1) == h_eff) ? '0 : yy + CW'(1);
        ym = (yy == '0) ? h_eff - CW'(1) : yy - CW'(1);
    end

    assign status.in_range = (xx < w_eff) && (yy < h_eff);
    assign status.kind     = kind_reg;
    assign status.half     = h_reg;

    // Source of the value that the current slot reads.
    slot_src_t     sel;
    logic [2:0]    pat;
    logic [1:0]    rd_comp;
    logic          rd_hf;
    logic [CW-1:0] rd_cx, rd_cy;

    always_comb
    begin
        pat     = 3'(cmd.comp) + (h_reg ? 3'd3 : 3'd0);
        sel     = slot_src(pat, 2'(cmd.slot - 3'd1));
        rd_comp = cmd.comp;
        rd_hf   = h_reg;
        rd_cx   = xx;
        rd_cy   = yy;
        if (cmd.slot != 3'd0)
        begin
            rd_comp = sel.comp;
            rd_hf   = sel.hf;
            unique case (sel.dx)
                NB_PLUS:  rd_cx = xp;
                NB_MINUS: rd_cx = xm;
                default:  rd_cx = xx;
            endcase
            unique case (sel.dy)
                NB_PLUS:  rd_cy = yp;
                NB_MINUS: rd_cy = ym;
                default:  rd_cy = yy;
            endcase
        end
    end

    // Read and write addresses, and write data for loads.
    logic [MAW-1:0]    med_wa, med_ra;
    logic [LAW-1:0]    lay_a;
    logic [DATA_W-1:0] wd_m, wd_f, wl_m, wl_f;

    always_comb
    begin
        med_wa = med_addr(cmd.comp, h_reg, xx, yy);
        med_ra = med_addr(rd_comp, rd_hf, rd_cx, rd_cy);
        lay_a  = lay_addr(cmd.comp[0], xx, yy);
        unique case (cmd.comp)
            2'd0:    begin wd_m = ma_reg; wd_f = fa_reg; end
            2'd1:    begin wd_m = mb_reg; wd_f = fb_reg; end
            default: begin wd_m = mc_reg; wd_f = fc_reg; end
        endcase
        wl_m = cmd.comp[0] ? mb_reg : ma_reg;
        wl_f = cmd.comp[0] ? fb_reg : fa_reg;
    end

    // Cell and layer stores, one write and one registered read each.
    logic [DATA_W-1:0] med_mem    [0:MED_DEPTH-1];
    logic [DATA_W-1:0] fac_mem    [0:MED_DEPTH-1];
    logic [DATA_W-1:0] lo_med_mem [0:LAY_DEPTH-1];
    logic [DATA_W-1:0] lo_fac_mem [0:LAY_DEPTH-1];
    logic [DATA_W-1:0] up_med_mem [0:LAY_DEPTH-1];
    logic [DATA_W-1:0] up_fac_mem [0:LAY_DEPTH-1];
    logic [DATA_W-1:0] med_rd, fac_rd, lo_med_rd, lo_fac_rd, up_med_rd, up_fac_rd;
    logic              lo_we, up_we;

    assign lo_we = cmd.wr_layer && (kind_reg == KIND_LOWER);
    assign up_we = cmd.wr_layer && (kind_reg == KIND_UPPER);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_cell)
        begin
            med_mem[med_wa] <= wd_m;
        end
        if (cmd.rd)
        begin
            med_rd <= med_mem[med_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_cell)
        begin
            fac_mem[med_wa] <= wd_f;
        end
        if (cmd.rd)
        begin
            fac_rd <= fac_mem[med_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lo_we)
        begin
            lo_med_mem[lay_a] <= wl_m;
        end
        if (cmd.rd)
        begin
            lo_med_rd <= lo_med_mem[lay_a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lo_we)
        begin
            lo_fac_mem[lay_a] <= wl_f;
        end
        if (cmd.rd)
        begin
            lo_fac_rd <= lo_fac_mem[lay_a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_we)
        begin
            up_med_mem[lay_a] <= wl_m;
        end
        if (cmd.rd)
        begin
            up_med_rd <= up_med_mem[lay_a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_we)
        begin
            up_fac_mem[lay_a] <= wl_f;
        end
        if (cmd.rd)
        begin
            up_fac_rd <= up_fac_mem[lay_a];
        end
    end

    // Accumulation of the medium sum and the two factor pairs.
    logic signed [DATA_W-1:0] self_m_reg, self_f_reg, mv, fv;
    logic signed [DATA_W+1:0] s_acc;
    logic signed [DATA_W:0]   pa_acc, pb_acc;
    logic signed [DATA_W+1:0] s_shift;
    logic signed [DATA_W:0]   pa_shift, pb_shift;
    logic signed [DATA_W-1:0] s4, pa, pb;

    always_comb
    begin
        if (sel.layer)
        begin
            mv = h_reg ? up_med_rd : lo_med_rd;
            fv = h_reg ? up_fac_rd : lo_fac_rd;
        end
        else
        begin
            mv = med_rd;
            fv = fac_rd;
        end
        s_shift  = s_acc >>> 2;
        pa_shift = pa_acc >>> 1;
        pb_shift = pb_acc >>> 1;
        s4 = s_shift[DATA_W-1:0];
        pa = pa_shift[DATA_W-1:0];
        pb = pb_shift[DATA_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc)
        begin
            if (cmd.slot == 3'd0)
            begin
                self_m_reg <= $signed(med_rd);
                self_f_reg <= $signed(fac_rd);
                s_acc      <= '0;
                pa_acc     <= '0;
                pb_acc     <= '0;
            end
            else
            begin
                s_acc <= s_acc + (DATA_W+2)'(mv);
                if (cmd.slot <= 3'd2)
                begin
                    pa_acc <= pa_acc + (DATA_W+1)'(fv);
                end
                else
                begin
                    pb_acc <= pb_acc + (DATA_W+1)'(fv);
                end
            end
        end
    end

    // Shared multiplier with its product register.
    logic signed [DATA_W:0]     opa, opb;
    logic signed [2*DATA_W+1:0] p_reg;
    logic signed [49:0]         ps;
    logic signed [51:0]         tacc_reg, sat_in;
    logic [DATA_W:0]            sat_out;
    logic signed [DATA_W-1:0]   e_reg, term_reg, t_reg, eta_reg;

    always_comb
    begin
        unique case (cmd.op)
            OP_E:    begin opa = 33'(s4);         opb = 33'(self_m_reg); end
            OP_PAPB: begin opa = 33'(pa);         opb = 33'(pb);         end
            OP_PBSF: begin opa = 33'(pb);         opb = 33'(self_f_reg); end
            OP_SFPA: begin opa = 33'(self_f_reg); opb = 33'(pa);         end
            OP_T:    begin opa = 33'(e_reg);      opb = 33'(term_reg);   end
            OP_ETA:  begin opa = $signed({2'b00, gain_reg}); opb = 33'(t_reg); end
            default: begin opa = '0;              opb = '0;              end
        endcase
        ps      = p_reg[2*DATA_W+1:16];
        sat_in  = (cmd.op == OP_SFPA) ? tacc_reg + 52'(ps) : 52'(ps);
        sat_out = sat32(sat_in);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            p_reg <= opa * opb;
        end
        if (cmd.macc)
        begin
            unique case (cmd.op)
                OP_E:    e_reg    <= sat_out[DATA_W-1:0];
                OP_PAPB: tacc_reg <= 52'(ps);
                OP_PBSF: tacc_reg <= tacc_reg + 52'(ps);
                OP_SFPA: term_reg <= sat_out[DATA_W-1:0];
                OP_T:    t_reg    <= sat_out[DATA_W-1:0];
                OP_ETA:  eta_reg  <= sat_out[DATA_W-1:0];
                default: ;
            endcase
        end
    end

    // Divider set-up: magnitudes and signs of dividend and divisor.
    logic signed [DATA_W:0] den, den_abs, sf_abs;

    always_comb
    begin
        den     = 33'sd65536 + 33'(eta_reg);
        den_abs = den[DATA_W] ? -den : den;
        sf_abs  = self_f_reg[DATA_W-1] ? -(33'(self_f_reg)) : 33'(self_f_reg);
    end

    // Restoring divider, one quotient bit per cycle.
    logic [DATA_W-1:0]   den_reg, rem_reg;
    logic [DIV_ITER-1:0] num_reg, q_reg;
    logic                neg_reg, zero_reg;
    logic [DATA_W:0]     trial;

    assign trial = {rem_reg, num_reg[DIV_ITER-1]};

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            den_reg  <= den_abs[DATA_W-1:0];
            num_reg  <= {sf_abs[DATA_W-1:0], 16'h0000};
            rem_reg  <= '0;
            q_reg    <= '0;
            neg_reg  <= self_f_reg[DATA_W-1] ^ den[DATA_W];
            zero_reg <= (den == '0);
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[DIV_ITER-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_reg <= DATA_W'(trial - {1'b0, den_reg});
                q_reg   <= {q_reg[DIV_ITER-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[DATA_W-1:0];
                q_reg   <= {q_reg[DIV_ITER-2:0], 1'b0};
            end
        end
    end

    // Sign fix, saturation and zero-divisor handling of the quotient.
    logic [DATA_W-1:0]   res_val;
    logic                res_sat;
    logic [DIV_ITER-1:0] q_neg;

    always_comb
    begin
        q_neg   = -q_reg;
        res_sat = 1'b0;
        if (zero_reg)
        begin
            res_sat = 1'b1;
            if (self_f_reg > 0)
            begin
                res_val = 32'h7FFF_FFFF;
            end
            else if (self_f_reg < 0)
            begin
                res_val = 32'h8000_0000;
            end
            else
            begin
                res_val = '0;
            end
        end
        else if (neg_reg)
        begin
            if (q_reg > 48'h0000_8000_0000)
            begin
                res_sat = 1'b1;
                res_val = 32'h8000_0000;
            end
            else
            begin
                res_val = q_neg[DATA_W-1:0];
            end
        end
        else
        begin
            if (q_reg > 48'h0000_7FFF_FFFF)
            begin
                res_sat = 1'b1;
                res_val = 32'h7FFF_FFFF;
            end
            else
            begin
                res_val = q_reg[DATA_W-1:0];
            end
        end
    end

    // Result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.div_end)
        begin
            unique case (cmd.comp)
                2'd0:    corrected_a <= res_val;
                2'd1:    corrected_b <= res_val;
                default: corrected_c <= res_val;
            endcase
        end
    end

    // Saturation flag and result strobe.
    logic flag_reg, done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
            if (cmd.load_item)
            begin
                flag_reg <= 1'b0;
            end
            else if ((cmd.macc && sat_out[DATA_W] && (cmd.op != OP_PAPB) &&
                      (cmd.op != OP_PBSF)) || (cmd.div_end && res_sat))
            begin
                flag_reg <= 1'b1;
            end
        end
    end

    assign done      = done_reg;
    assign saturated = flag_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_half  = h_reg;

endmodule

>>> tb/sv/ycf_checker.sv
// Checker for the Yee cell correction factor unit: follows the item, result and
// register channels, predicts each query result and compares it. Uses ycf_pkg.
`timescale 1ns / 1ps

module ycf_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [30:0] cfg_wdata,
    input  logic [1:0]  kind,
    input  logic [5:0]  cell_x,
    input  logic [5:0]  cell_y,
    input  logic        half,
    input  logic [31:0] med_a,
    input  logic [31:0] med_b,
    input  logic [31:0] med_c,
    input  logic [31:0] fac_a,
    input  logic [31:0] fac_b,
    input  logic [31:0] fac_c,
    input  logic        done,
    input  logic [5:0]  out_x,
    input  logic [5:0]  out_y,
    input  logic        out_half,
    input  logic [31:0] corrected_a,
    input  logic [31:0] corrected_b,
    input  logic [31:0] corrected_c,
    input  logic        saturated,
    input  logic        end_of_run,
    output int          fail_count,
    output int          pending,
    output int          checked
);
    import ycf_pkg::*;

    localparam longint ONE_Q = 65536;

    typedef struct {
        logic [5:0]  x;
        logic [5:0]  y;
        logic        h;
        logic [31:0] corr[3];
        logic        sat;
    } correction_t;

    correction_t expected_corrections[$];

    // Local copy of the stores and the registers.
    logic [31:0] medium_mem[24576];
    logic [31:0] factor_mem[24576];
    logic [31:0] lower_mem[16384];
    logic [31:0] upper_mem[16384];
    logic [6:0]  width_reg;
    logic [6:0]  height_reg;
    logic [30:0] gain_reg;

    assign pending = expected_corrections.size();

    initial begin
        fail_count = 0;
        checked = 0;
        width_reg = 7'd64;
        height_reg = 7'd64;
        gain_reg = '0;
    end

    task automatic report(input string what);
        $display("%0t ns mismatch: %s", $time, what);
        fail_count++;
    endtask

    function automatic int eff_size(input logic [6:0] v);
        if (v == 0) return 1;
        return (v > 64) ? 64 : int'(v);
    endfunction

    function automatic longint med(input int c, input int h, input int x, input int y);
        return longint'($signed(medium_mem[c + 3 * h + 6 * (x + 64 * y)]));
    endfunction

    function automatic longint fac(input int c, input int h, input int x, input int y);
        return longint'($signed(factor_mem[c + 3 * h + 6 * (x + 64 * y)]));
    endfunction

    function automatic longint clip32(input longint v, inout bit flag);
        if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return (a * b) >>> 16;
    endfunction

    // Works out the corrected factors of one query.
    function automatic correction_t correct_cell(input int x, input int y, input int h);
        correction_t r;
        int w, hh, xp, xm, yp, ym, cell_idx;
        bit flag;
        longint lo_m, lo_f, up_m, up_f, s, d0, d1, d2, self_m, self_f;
        longint e, term, t, eta, dv, q;
        w = eff_size(width_reg);
        hh = eff_size(height_reg);
        xp = (x + 1 == w) ? 0 : x + 1;
        xm = (x == 0) ? w - 1 : x - 1;
        yp = (y + 1 == hh) ? 0 : y + 1;
        ym = (y == 0) ? hh - 1 : y - 1;
        cell_idx = x + 64 * y;
        flag = 1'b0;
        r.x = 6'(x);
        r.y = 6'(y);
        r.h = 1'(h);
        for (int c = 0; c < 3; c++) begin
            lo_m = longint'($signed(lower_mem[c + 4 * cell_idx]));
            lo_f = longint'($signed(lower_mem[2 + c + 4 * cell_idx]));
            up_m = longint'($signed(upper_mem[c + 4 * cell_idx]));
            up_f = longint'($signed(upper_mem[2 + c + 4 * cell_idx]));
            self_m = med(c, h, x, y);
            self_f = fac(c, h, x, y);
            d0 = 0;
            d1 = 0;
            d2 = 0;
            case (c + 3 * h)
                0: begin
                    s = med(0, 1, x, y) + lo_m + med(2, 0, x, y) + med(2, 0, x, ym);
                    d0 = self_f;
                    d1 = (fac(0, 1, x, y) + lo_f) >>> 1;
                    d2 = (fac(2, 0, x, y) + fac(2, 0, x, ym)) >>> 1;
                end
                1: begin
                    s = med(1, 1, x, y) + lo_m + med(2, 0, x, y) + med(2, 0, xm, y);
                    d1 = self_f;
                    d2 = (fac(2, 0, x, y) + fac(2, 0, xm, y)) >>> 1;
                    d0 = (fac(1, 1, x, y) + lo_f) >>> 1;
                end
                2: begin
                    s = med(0, 0, x, y) + med(0, 0, x, yp) + med(1, 0, x, y)
                        + med(1, 0, xp, y);
                    d2 = self_f;
                    d0 = (fac(0, 0, x, y) + fac(0, 0, x, yp)) >>> 1;
                    d1 = (fac(1, 0, x, y) + fac(1, 0, xp, y)) >>> 1;
                end
                3: begin
                    s = med(0, 0, x, y) + up_m + med(2, 1, x, y) + med(2, 1, xp, y);
                    d1 = self_f;
                    d2 = (fac(2, 1, xp, y) + fac(2, 1, x, y)) >>> 1;
                    d0 = (fac(0, 0, x, y) + up_f) >>> 1;
                end
                4: begin
                    s = med(1, 0, x, y) + up_m + med(2, 1, x, y) + med(2, 1, x, yp);
                    d0 = self_f;
                    d1 = (fac(1, 0, x, y) + up_f) >>> 1;
                    d2 = (fac(2, 1, x, yp) + fac(2, 1, x, y)) >>> 1;
                end
                default: begin
                    s = med(0, 1, x, y) + med(0, 1, xm, y) + med(1, 1, x, y)
                        + med(1, 1, x, ym);
                    d2 = self_f;
                    d1 = (fac(0, 1, x, y) + fac(0, 1, xm, y)) >>> 1;
                    d0 = (fac(1, 1, x, y) + fac(1, 1, x, ym)) >>> 1;
                end
            endcase
            e = clip32(qmul(self_m, s >>> 2), flag);
            term = clip32(qmul(d1, d2) + qmul(d2, d0) + qmul(d0, d1), flag);
            t = clip32(qmul(e, term), flag);
            eta = clip32(qmul(longint'(gain_reg), t), flag);
            dv = ONE_Q + eta;
            // A zero divisor saturates towards the sign of the factor.
            if (dv == 0) begin
                flag = 1'b1;
                q = (self_f > 0) ? 64'sd2147483647 : ((self_f < 0) ? -64'sd2147483648 : 0);
            end else begin
                q = clip32((self_f * ONE_Q) / dv, flag);
            end
            r.corr[c] = q[31:0];
        end
        r.sat = flag;
        return r;
    endfunction

    // Register writes, accepted items and results, all seen at the rising edge.
    always @(posedge clk) begin
        int w, hh, cell_idx;
        correction_t got, exp_r;
        if (rst_n && cfg_we) begin
            case (cfg_addr)
                REG_GRID_WIDTH:  width_reg = cfg_wdata[6:0];
                REG_GRID_HEIGHT: height_reg = cfg_wdata[6:0];
                REG_ETA_GAIN:    gain_reg = cfg_wdata;
                default: ;
            endcase
        end
        if (rst_n && start && !busy) begin
            w = eff_size(width_reg);
            hh = eff_size(height_reg);
            cell_idx = cell_x + 64 * cell_y;
            if (cell_x < w && cell_y < hh) begin
                case (kind_t'(kind))
                    KIND_CELL: begin
                        medium_mem[3 * half + 6 * cell_idx] = med_a;
                        medium_mem[1 + 3 * half + 6 * cell_idx] = med_b;
                        medium_mem[2 + 3 * half + 6 * cell_idx] = med_c;
                        factor_mem[3 * half + 6 * cell_idx] = fac_a;
                        factor_mem[1 + 3 * half + 6 * cell_idx] = fac_b;
                        factor_mem[2 + 3 * half + 6 * cell_idx] = fac_c;
                    end
                    KIND_LOWER: if (half) begin
                        lower_mem[4 * cell_idx] = med_a;
                        lower_mem[1 + 4 * cell_idx] = med_b;
                        lower_mem[2 + 4 * cell_idx] = fac_a;
                        lower_mem[3 + 4 * cell_idx] = fac_b;
                    end
                    KIND_UPPER: if (!half) begin
                        upper_mem[4 * cell_idx] = med_a;
                        upper_mem[1 + 4 * cell_idx] = med_b;
                        upper_mem[2 + 4 * cell_idx] = fac_a;
                        upper_mem[3 + 4 * cell_idx] = fac_b;
                    end
                    default: expected_corrections.push_back(correct_cell(cell_x, cell_y, half));
                endcase
            end
        end
        if (rst_n && done) begin
            got.x = out_x;
            got.y = out_y;
            got.h = out_half;
            got.corr[0] = corrected_a;
            got.corr[1] = corrected_b;
            got.corr[2] = corrected_c;
            got.sat = saturated;
            checked++;
            if (expected_corrections.size() == 0) begin
                report($sformatf("result for cell (%0d,%0d) with none expected", out_x, out_y));
            end else begin
                exp_r = expected_corrections.pop_front();
                if (got.x !== exp_r.x || got.y !== exp_r.y || got.h !== exp_r.h)
                    report($sformatf("cell (%0d,%0d,%0d), expected (%0d,%0d,%0d)",
                        got.x, got.y, got.h, exp_r.x, exp_r.y, exp_r.h));
                for (int c = 0; c < 3; c++)
                    if (got.corr[c] !== exp_r.corr[c])
                        report($sformatf("corrected[%0d] %h, expected %h at (%0d,%0d,%0d)",
                            c, got.corr[c], exp_r.corr[c], exp_r.x, exp_r.y, exp_r.h));
                if (got.sat !== exp_r.sat)
                    report($sformatf("saturated %b, expected %b at (%0d,%0d,%0d)",
                        got.sat, exp_r.sat, exp_r.x, exp_r.y, exp_r.h));
            end
        end
    end

    // Anything still expected once the run has drained is lost.
    always @(posedge end_of_run) begin
        if (expected_corrections.size() != 0)
            report($sformatf("%0d results never arrived", expected_corrections.size()));
    end

endmodule

>>> tb/sv/tb.sv
// Top of the testbench: clock, reset, register writes and item stimulus for the
// unit, with ycf_checker beside it. Depends on ycf_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
    import ycf_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [30:0] cfg_wdata;
    logic [1:0]  kind;
    logic [5:0]  cell_x;
    logic [5:0]  cell_y;
    logic        half;
    logic [31:0] med_a, med_b, med_c, fac_a, fac_b, fac_c;
    logic        done;
    logic [5:0]  out_x, out_y;
    logic        out_half;
    logic [31:0] corrected_a, corrected_b, corrected_c;
    logic        saturated;
    logic        end_of_run;
    int          fail_count, pending, checked;
    int          items_sent, settings_seen;
    bit          calm;
    int          grid_w, grid_h;

    yee_cell_correction_factor_unit DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .kind(kind), .cell_x(cell_x), .cell_y(cell_y), .half(half),
        .med_a(med_a), .med_b(med_b), .med_c(med_c),
        .fac_a(fac_a), .fac_b(fac_b), .fac_c(fac_c),
        .done(done), .out_x(out_x), .out_y(out_y), .out_half(out_half),
        .corrected_a(corrected_a), .corrected_b(corrected_b),
        .corrected_c(corrected_c), .saturated(saturated)
    );

    ycf_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .kind(kind), .cell_x(cell_x), .cell_y(cell_y), .half(half),
        .med_a(med_a), .med_b(med_b), .med_c(med_c),
        .fac_a(fac_a), .fac_b(fac_b), .fac_c(fac_c),
        .done(done), .out_x(out_x), .out_y(out_y), .out_half(out_half),
        .corrected_a(corrected_a), .corrected_b(corrected_b),
        .corrected_c(corrected_c), .saturated(saturated),
        .end_of_run(end_of_run), .fail_count(fail_count), .pending(pending),
        .checked(checked)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Hard stop should the unit hang.
    initial
    begin
        #40ms;
        $display("Timeout with %0d results still expected", pending);
        $display("*** FAILED ***");
        $finish;
    end

    // Data value: extremes, values near one, or anything.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3, 4: return $urandom();
            default: return 32'($signed($urandom_range(0, 32'h6_0000)) - 32'sh3_0000);
        endcase
    endfunction

    // Presents one item and waits for it to be taken; called at a falling edge.
    task automatic send_item(input kind_t k, input int x, input int y, input bit h,
                             input logic [31:0] ma, mb, mc, fa, fb, fc);
        if (!calm && $urandom_range(0, 3) == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        start = 1'b1;
        kind = k;
        cell_x = 6'(x);
        cell_y = 6'(y);
        half = h;
        {med_a, med_b, med_c, fac_a, fac_b, fac_c} = {ma, mb, mc, fa, fb, fc};
        forever begin
            @(posedge clk);
            if (!busy) break;
        end
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_random(input kind_t k, input int x, input int y, input bit h);
        send_item(k, x, y, h, pick_value(), pick_value(), pick_value(),
                  pick_value(), pick_value(), pick_value());
    endtask

    // Lets the unit drain before a register write.
    task automatic wait_idle();
        start = 1'b0;
        while (pending != 0 || busy) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [30:0] value);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // New grid and gain; then every cell of the grid gets all its records.
    task automatic new_setting(input logic [6:0] w, input logic [6:0] h, input logic [30:0] g);
        wait_idle();
        write_reg(REG_GRID_WIDTH, 31'(w));
        write_reg(REG_GRID_HEIGHT, 31'(h));
        write_reg(REG_ETA_GAIN, g);
        grid_w = (w == 0) ? 1 : ((w > 64) ? 64 : w);
        grid_h = (h == 0) ? 1 : ((h > 64) ? 64 : h);
        settings_seen++;
        for (int y = 0; y < grid_h; y++)
            for (int x = 0; x < grid_w; x++) begin
                send_random(KIND_CELL, x, y, 1'b0);
                send_random(KIND_CELL, x, y, 1'b1);
                send_random(KIND_LOWER, x, y, 1'b1);
                send_random(KIND_UPPER, x, y, 1'b0);
            end
    endtask

    // Mostly queries and loads inside the grid, some outside or mismatched.
    task automatic random_items(input int count);
        int x, y;
        kind_t k;
        for (int i = 0; i < count; i++) begin
            x = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, grid_w - 1);
            y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, grid_h - 1);
            k = ($urandom_range(0, 1) == 0) ? KIND_QUERY : kind_t'($urandom_range(0, 2));
            send_random(k, x, y, 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        logic [31:0] pos_one, neg_one;
        pos_one = 32'h0001_0000;
        neg_one = 32'hFFFF_0000;
        rst_n = 1'b0;
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        kind = '0;
        cell_x = '0;
        cell_y = '0;
        half = 1'b0;
        {med_a, med_b, med_c, fac_a, fac_b, fac_c} = '0;
        end_of_run = 1'b0;
        calm = 1'b0;
        items_sent = 0;
        settings_seen = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Single cell with unit gain, set up so that the divisor becomes zero.
        new_setting(7'd0, 7'd0, 31'h0001_0000);
        send_item(KIND_CELL, 0, 0, 1'b0, neg_one, pos_one, pos_one, pos_one, pos_one, 0);
        send_item(KIND_CELL, 0, 0, 1'b1, pos_one, pos_one, pos_one,
                  pos_one, pos_one, pos_one);
        send_item(KIND_LOWER, 0, 0, 1'b1, pos_one, pos_one, 0, pos_one, pos_one, 0);
        send_item(KIND_UPPER, 0, 0, 1'b0, pos_one, pos_one, 0, pos_one, pos_one, 0);
        send_item(KIND_QUERY, 0, 0, 1'b0, 0, 0, 0, 0, 0, 0);
        send_item(KIND_QUERY, 0, 0, 1'b1, 0, 0, 0, 0, 0, 0);
        // Ignored items: outside the grid, and layer records for the wrong half.
        send_item(KIND_QUERY, 1, 0, 1'b0, 0, 0, 0, 0, 0, 0);
        send_item(KIND_CELL, 0, 5, 1'b0, 0, 0, 0, 0, 0, 0);
        send_item(KIND_LOWER, 0, 0, 1'b0, 0, 0, 0, 0, 0, 0);
        send_item(KIND_UPPER, 0, 0, 1'b1, 0, 0, 0, 0, 0, 0);
        send_item(KIND_QUERY, 0, 0, 1'b0, 0, 0, 0, 0, 0, 0);
        // Field extremes in the half-0 cell record and the lower layer record.
        send_item(KIND_CELL, 0, 0, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(KIND_LOWER, 0, 0, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 0,
                  32'h8000_0000, 32'h8000_0000, 0);
        send_item(KIND_QUERY, 0, 0, 1'b0, 0, 0, 0, 0, 0, 0);
        send_item(KIND_QUERY, 0, 0, 1'b1, 0, 0, 0, 0, 0, 0);

        // Random phases over several grids and gains, the extremes among them.
        new_setting(7'd127, 7'd1, 31'h7FFF_FFFF);
        random_items(25);
        new_setting(7'd1, 7'd3, 31'd0);
        random_items(25);
        new_setting(7'd2, 7'd4, 31'h0000_4000);
        random_items(25);
        for (int p = 0; p < 5; p++) begin
            new_setting(7'($urandom_range(1, 4)), 7'($urandom_range(1, 4)),
                        ($urandom_range(0, 1) == 0) ? 31'($urandom_range(0, 32'h3_0000))
                                                    : 31'($urandom_range(0, 32'h7FFF_FFFF)));
            calm = (p == 4);
            random_items(25);
        end

        // Drain, then allow one more query's worth of cycles.
        start = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (250) @(negedge clk);
        end_of_run = 1'b1;
        @(negedge clk);
        $display("Sent %0d items over %0d grid and gain settings; %0d results compared.",
                 items_sent, settings_seen, checked);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
src/ycf_pkg.sv
src/ycf_ctrl.sv
src/ycf_datapath.sv
src/yee_cell_correction_factor_unit.sv
tb/sv/ycf_checker.sv
tb/sv/tb.sv
